// File: src/lvs_pkg.sv
`timescale 1ns / 1ps
package lvs_pkg;

  localparam int unsigned SLOTS      = 5;
  localparam int unsigned STAMP_BITS = 32;
  localparam int unsigned SLOT_W     = 3;

  localparam logic [SLOT_W-1:0] SLOT_NONE = 3'd7;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [STAMP_BITS-1:0] stamp_t;
  typedef logic [SLOTS-1:0]      mask_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } lvs_cmd_t;

  typedef struct packed {
    logic last;
  } lvs_status_t;

endpackage

// File: src/lru_victim_select.sv
`timescale 1ns / 1ps
// Picks the least recently used unlocked slot, excluding the current one,
// and stamps it. A request is taken when start is high and busy is low; the
// scan state compares the 5 slots one after another, the update state then
// stamps the victim and registers the result, and valid_o marks the result
// for a single cycle. The receiver cannot stall: sample the result when
// valid_o is high. A new request may be issued in the same cycle that
// valid_o is shown; busy holds off a new request while one is in flight.
module lru_victim_select (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [4:0]            lock_mask_i,
  output logic                  valid_o,
  output logic                  victim_found_o,
  output logic [2:0]            victim_slot_o,
  output logic [31:0]           victim_stamp_o,
  output logic                  prior_valid_o,
  output logic [2:0]            prior_slot_o
);
  import lvs_pkg::*;

  lvs_cmd_t    cmd;
  lvs_status_t status;

  lvs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .valid_o  (valid_o),
    .status_i (status),
    .cmd_o    (cmd)
  );

  lvs_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .lock_mask_i    (lock_mask_i),
    .victim_found_o (victim_found_o),
    .victim_slot_o  (victim_slot_o),
    .victim_stamp_o (victim_stamp_o),
    .prior_valid_o  (prior_valid_o),
    .prior_slot_o   (prior_slot_o)
  );

endmodule

// File: src/lvs_ctrl.sv
`timescale 1ns / 1ps
module lvs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  output logic                valid_o,
  input  lvs_pkg::lvs_status_t status_i,
  output lvs_pkg::lvs_cmd_t    cmd_o
);
  import lvs_pkg::*;

  state_e state_q, state_d;
  logic   valid_q, valid_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (status_i.last) state_d = ST_UPDATE;
      end
      ST_UPDATE: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o   = '0;
    busy    = 1'b1;
    valid_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      ST_SCAN: cmd_o.step = 1'b1;
      ST_UPDATE: begin
        cmd_o.commit = 1'b1;
        valid_d      = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  assign valid_o = valid_q;

endmodule

// File: src/lvs_datapath.sv
`timescale 1ns / 1ps
module lvs_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lvs_pkg::lvs_cmd_t    cmd_i,
  output lvs_pkg::lvs_status_t status_o,
  input  lvs_pkg::mask_t       lock_mask_i,
  output logic                 victim_found_o,
  output lvs_pkg::slot_t       victim_slot_o,
  output lvs_pkg::stamp_t      victim_stamp_o,
  output logic                 prior_valid_o,
  output lvs_pkg::slot_t       prior_slot_o
);
  import lvs_pkg::*;

  stamp_t stamps_q [SLOTS];
  mask_t  mask_q;
  slot_t  idx_q, best_q, cur_q, prev_q, earlier_q;
  stamp_t best_stamp_q, base_q;
  logic   found_q;

  logic   res_found_q, res_prior_valid_q;
  slot_t  res_slot_q, res_prior_slot_q;
  stamp_t res_stamp_q;

  stamp_t rd_stamp;
  logic   have_cur, is_cur, eligible, take;
  stamp_t new_stamp;

  assign rd_stamp  = stamps_q[idx_q];
  assign have_cur  = (cur_q != SLOT_NONE);
  assign is_cur    = have_cur && (idx_q == cur_q);
  assign eligible  = !mask_q[idx_q] && !is_cur;
  assign take      = eligible && (rd_stamp <= best_stamp_q);
  assign new_stamp = base_q + STAMP_BITS'(1);

  assign status_o.last = (idx_q == SLOT_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) stamps_q[i] <= '0;
      cur_q     <= SLOT_NONE;
      prev_q    <= SLOT_NONE;
      earlier_q <= SLOT_NONE;
    end else if (cmd_i.commit) begin
      earlier_q <= prev_q;
      prev_q    <= cur_q;
      cur_q     <= found_q ? best_q : SLOT_NONE;
      if (found_q) stamps_q[best_q] <= new_stamp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mask_q       <= lock_mask_i;
      idx_q        <= '0;
      best_q       <= SLOT_NONE;
      best_stamp_q <= '1;
      found_q      <= 1'b0;
      base_q       <= '0;
    end else if (cmd_i.step) begin
      if (!status_o.last) idx_q <= idx_q + SLOT_W'(1);
      if (take) begin
        best_q       <= idx_q;
        best_stamp_q <= rd_stamp;
        found_q      <= 1'b1;
      end
      if (is_cur) base_q <= rd_stamp;
    end
    if (cmd_i.commit) begin
      res_found_q       <= found_q;
      res_slot_q        <= found_q ? best_q : '0;
      res_stamp_q       <= found_q ? new_stamp : '0;
      res_prior_valid_q <= have_cur;
      res_prior_slot_q  <= have_cur ? cur_q : '0;
    end
  end

  assign victim_found_o = res_found_q;
  assign victim_slot_o  = res_slot_q;
  assign victim_stamp_o = res_stamp_q;
  assign prior_valid_o  = res_prior_valid_q;
  assign prior_slot_o   = res_prior_slot_q;

endmodule
